@@ rtl/npc_pkg.sv @@
// npc_pkg: shared types, codes and helpers for the nearest palette color search.
// No dependencies; used by the channel interfaces, npc_cell and nearest_palette_color.
`default_nettype none

package npc_pkg;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned DIST_W  = 10;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [DIST_W-1:0] DIST_START = 10'd1000;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [DIST_W-1:0] dist_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } color_t;

  // beat moving down the cell row
  typedef struct packed {
    logic               valid;
    logic               opcode;
    logic [INDEX_W-1:0] entry_index;
    color_t             color;
    dist_t              best_dist;
  } npc_tok_t;

  function automatic dist_t absdiff(input chan_t a, input chan_t b);
    chan_t d;
    d = (a > b) ? (a - b) : (b - a);
    return dist_t'(d);
  endfunction

  function automatic dist_t color_dist(input color_t a, input color_t b);
    return absdiff(a.red, b.red) + absdiff(a.green, b.green) + absdiff(a.blue, b.blue);
  endfunction

endpackage

`default_nettype wire

@@ rtl/npc_in_if.sv @@
// npc_in_if: input channel (load or query beat) with valid/ready handshake.
// Depends on npc_pkg.
`default_nettype none

interface npc_in_if;
  import npc_pkg::*;

  logic               valid;
  logic               ready;
  logic               opcode;
  logic [INDEX_W-1:0] entry_index;
  chan_t              red;
  chan_t              green;
  chan_t              blue;

  modport source (output valid, opcode, entry_index, red, green, blue, input ready);
  modport sink   (input valid, opcode, entry_index, red, green, blue, output ready);
endinterface

`default_nettype wire

@@ rtl/npc_out_if.sv @@
// npc_out_if: result channel carrying the closest palette index.
// Depends on npc_pkg.
`default_nettype none

interface npc_out_if;
  import npc_pkg::*;

  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] closest_index;

  modport source (output valid, closest_index, input ready);
  modport sink   (input valid, closest_index, output ready);
endinterface

`default_nettype wire

@@ rtl/nearest_palette_color.sv @@
// nearest_palette_color: top level, a row of PALETTE_ENTRIES search cells.
// Depends on npc_pkg, npc_in_if, npc_out_if and npc_cell.
//
//   channel  | dir | beat
//   in_bus   | in  | opcode, entry_index, red, green, blue (load or query)
//   out_bus  | out | closest_index (one per query, none per load)
//
// Each beat walks the cell row, one cell per cycle, and a new beat may enter
// every cycle while no result stalls at the output.
// A load is written by the cell whose index matches as it passes; later queries
// see it, earlier ones already passed. Loads beyond the palette fall off the end.
// The last cell's stage is the output register; while a result stalls there the
// whole row holds and in_bus.ready is low. Reset clears only the valid bits.
`default_nettype none

module nearest_palette_color #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input wire logic clk,
  input wire logic rst_n,
  npc_in_if.sink   in_bus,
  npc_out_if.source out_bus
);
  import npc_pkg::*;

  localparam int unsigned IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  npc_tok_t         tok  [PALETTE_ENTRIES+1];
  logic [IDX_W-1:0] bidx [PALETTE_ENTRIES+1];
  logic             adv;
  logic             tail_query;

  assign tok[0].valid       = in_bus.valid;
  assign tok[0].opcode      = in_bus.opcode;
  assign tok[0].entry_index = in_bus.entry_index;
  assign tok[0].color       = '{red: in_bus.red, green: in_bus.green, blue: in_bus.blue};
  assign tok[0].best_dist   = DIST_START;
  assign bidx[0]            = '0;

  for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
    npc_cell #(
      .CELL_ID (i),
      .IDX_W   (IDX_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv        (adv),
      .tok_i      (tok[i]),
      .best_idx_i (bidx[i]),
      .tok_o      (tok[i+1]),
      .best_idx_o (bidx[i+1])
    );
  end

  assign tail_query = tok[PALETTE_ENTRIES].valid && (tok[PALETTE_ENTRIES].opcode == OP_QUERY);
  assign adv        = !tail_query || out_bus.ready;

  assign in_bus.ready          = adv;
  assign out_bus.valid         = tail_query;
  assign out_bus.closest_index = INDEX_W'(bidx[PALETTE_ENTRIES]);

endmodule

`default_nettype wire

@@ rtl/npc_cell.sv @@
// npc_cell: one palette entry plus one stage of the search row.
// Depends on npc_pkg; instanced in a chain by nearest_palette_color.
`default_nettype none

module npc_cell #(
  parameter int unsigned CELL_ID = 0,
  parameter int unsigned IDX_W   = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire npc_pkg::npc_tok_t tok_i,
  input  wire logic [IDX_W-1:0] best_idx_i,
  output npc_pkg::npc_tok_t     tok_o,
  output logic      [IDX_W-1:0] best_idx_o
);
  import npc_pkg::*;

  color_t           entry_r;
  npc_tok_t         tok_r, tok_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic             hit_load;
  dist_t            cur_dist;

  assign hit_load = tok_i.valid && (tok_i.opcode == OP_LOAD) &&
                    (tok_i.entry_index == INDEX_W'(CELL_ID));
  assign cur_dist = color_dist(entry_r, tok_i.color);

  always_comb begin
    tok_nxt      = tok_i;
    best_idx_nxt = best_idx_i;
    if (tok_i.valid && (tok_i.opcode == OP_QUERY) && (cur_dist < tok_i.best_dist)) begin
      tok_nxt.best_dist = cur_dist;
      best_idx_nxt      = IDX_W'(CELL_ID);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && hit_load) begin
      entry_r <= tok_i.color;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else if (adv) begin
      tok_r.valid <= tok_nxt.valid;
    end
    if (adv) begin
      tok_r.opcode      <= tok_nxt.opcode;
      tok_r.entry_index <= tok_nxt.entry_index;
      tok_r.color       <= tok_nxt.color;
      tok_r.best_dist   <= tok_nxt.best_dist;
      best_idx_r        <= best_idx_nxt;
    end
  end

  assign tok_o      = tok_r;
  assign best_idx_o = best_idx_r;

endmodule

`default_nettype wire

@@ verif/palette_match_checker.sv @@
// palette_match_checker: watches the load/query and result channels of
// nearest_palette_color, keeps a shadow palette and checks every closest_index.
// Depends on npc_pkg, npc_in_if and npc_out_if.
`timescale 1ns / 100ps

module palette_match_checker #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  npc_in_if           in_mon,
  npc_out_if          out_mon,
  output int unsigned mismatches,
  output int unsigned pending,
  output int unsigned compared
);
  import npc_pkg::*;

  color_t              shadow_palette [ENTRIES];
  logic [INDEX_W-1:0]  expected_index_q [$];

  function automatic int unsigned chan_gap(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  // strict compare: lowest index wins a tie
  function automatic logic [INDEX_W-1:0] nearest_entry(input color_t c);
    int unsigned best;
    int unsigned span;
    int unsigned found;
    best  = 1000;
    found = 0;
    for (int unsigned i = 0; i < ENTRIES; i++) begin
      span = chan_gap(shadow_palette[i].red, c.red) + chan_gap(shadow_palette[i].green, c.green)
           + chan_gap(shadow_palette[i].blue, c.blue);
      if (span < best) begin
        best  = span;
        found = i;
      end
    end
    return found[INDEX_W-1:0];
  endfunction

  initial begin
    mismatches = 0;
    pending    = 0;
    compared   = 0;
  end

  always @(posedge clk) begin
    logic [INDEX_W-1:0] want;
    color_t             beat_color;
    if (!rst_n) begin
      for (int unsigned i = 0; i < ENTRIES; i++) shadow_palette[i] = '0;
      expected_index_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_index_q.size() == 0) begin
          $error("closest_index: unexpected beat, expected none, actual %0d",
                 out_mon.closest_index);
          mismatches++;
        end else begin
          want = expected_index_q.pop_front();
          compared++;
          if (out_mon.closest_index !== want) begin
            $error("closest_index: expected %0d, actual %0d", want, out_mon.closest_index);
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        beat_color = '{red: in_mon.red, green: in_mon.green, blue: in_mon.blue};
        if (in_mon.opcode == OP_LOAD) begin
          if (in_mon.entry_index < ENTRIES) shadow_palette[in_mon.entry_index] = beat_color;
        end else begin
          expected_index_q.push_back(nearest_entry(beat_color));
        end
      end
    end
    pending = expected_index_q.size();
  end

endmodule

@@ verif/nearest_palette_color_tb.sv @@
// nearest_palette_color_tb: drives palette loads and color queries with random
// idling on both channels; palette_match_checker predicts and compares.
// Depends on npc_pkg, npc_in_if, npc_out_if, nearest_palette_color, palette_match_checker.
`timescale 1ns / 100ps

module nearest_palette_color_tb;
  import npc_pkg::*;

  localparam int unsigned ENTRIES     = 256;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 300;

  logic        clk;
  logic        rst_n;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned compared;
  int unsigned cycles;
  int unsigned idle_pct;
  int unsigned stall_left;
  int unsigned loads_sent;
  int unsigned queries_sent;
  color_t      palette_img [ENTRIES];

  npc_in_if  in_bus ();
  npc_out_if out_bus ();

  nearest_palette_color #(.PALETTE_ENTRIES(ENTRIES)) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  palette_match_checker #(.ENTRIES(ENTRIES)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .mismatches (mismatches),
    .pending    (pending),
    .compared   (compared)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("nearest_palette_color verification failed");
      $finish;
    end
  end

  // result-side back pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      out_bus.ready <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left    <= $urandom_range(1, 18) - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  function automatic color_t any_color();
    color_t c;
    c.red   = chan_t'($urandom_range(0, 255));
    c.green = chan_t'($urandom_range(0, 255));
    c.blue  = chan_t'($urandom_range(0, 255));
    if ($urandom_range(0, 7) == 0) c.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    if ($urandom_range(0, 7) == 0) c.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    if ($urandom_range(0, 7) == 0) c.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return c;
  endfunction

  function automatic chan_t nudge(input chan_t v);
    int s;
    s = int'(v) + int'($urandom_range(0, 6)) - 3;
    if (s < 0) s = 0;
    if (s > 255) s = 255;
    return chan_t'(s);
  endfunction

  // entered and left at a falling edge
  task automatic send_beat(input logic op, input logic [INDEX_W-1:0] idx, input color_t c);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.opcode      <= op;
    in_bus.entry_index <= idx;
    in_bus.red         <= c.red;
    in_bus.green       <= c.green;
    in_bus.blue        <= c.blue;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_entry(input logic [INDEX_W-1:0] idx, input color_t c);
    palette_img[idx] = c;
    loads_sent++;
    send_beat(OP_LOAD, idx, c);
  endtask

  task automatic query_color(input color_t c);
    queries_sent++;
    send_beat(OP_QUERY, INDEX_W'($urandom_range(0, 255)), c);
  endtask

  initial begin
    color_t c;
    logic [INDEX_W-1:0] idx;
    cycles             = 0;
    idle_pct           = 0;
    stall_left         = 0;
    loads_sent         = 0;
    queries_sent       = 0;
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.opcode      = OP_LOAD;
    in_bus.entry_index = '0;
    in_bus.red         = '0;
    in_bus.green       = '0;
    in_bus.blue        = '0;
    out_bus.ready      = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    idle_pct = 10;
    for (int i = 0; i < ENTRIES; i++) load_entry(INDEX_W'(i), any_color());
    // duplicate colors: the lower index must win
    load_entry(8'd7,   '{red: 8'hFF, green: 8'h00, blue: 8'hFF});
    load_entry(8'd250, '{red: 8'hFF, green: 8'h00, blue: 8'hFF});
    load_entry(8'd255, '{red: 8'hFF, green: 8'hFF, blue: 8'hFF});
    load_entry(8'd0,   '{red: 8'h01, green: 8'h02, blue: 8'h03});
    query_color('{red: 8'hFF, green: 8'h00, blue: 8'hFF});
    query_color('{red: 8'hFF, green: 8'hFF, blue: 8'hFF});
    query_color('0);
    query_color('{red: 8'h80, green: 8'h80, blue: 8'h80});
    query_color('{red: 8'h01, green: 8'h02, blue: 8'h03});
    query_color('{red: 8'h00, green: 8'hFF, blue: 8'h00});
    query_color(palette_img[128]);

    // hold off until the pipe has handed back every result
    in_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk);

    for (int n = 0; n < 180; n++) begin
      if (n % 40 == 0) idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
      if (n >= 150) idle_pct = 0;
      idx = INDEX_W'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 45) begin
        if ($urandom_range(0, 3) == 0) c = palette_img[$urandom_range(0, 255)];
        else c = any_color();
        load_entry(idx, c);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: c = palette_img[idx];
          3, 4: begin
            c = palette_img[idx];
            c = '{red: nudge(c.red), green: nudge(c.green), blue: nudge(c.blue)};
          end
          default: c = any_color();
        endcase
        query_color(c);
      end
    end

    in_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("covered %0d palette loads and %0d color queries; %0d results compared",
             loads_sent, queries_sent, compared);
    if (mismatches == 0) begin
      $display("nearest_palette_color verification clean");
    end else begin
      $display("nearest_palette_color verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/npc_pkg.sv
rtl/npc_in_if.sv
rtl/npc_out_if.sv
rtl/npc_cell.sv
rtl/nearest_palette_color.sv
verif/palette_match_checker.sv
verif/nearest_palette_color_tb.sv
